// File: design/wscc_pkg.sv
package wscc_pkg;

  localparam int QUEUE_DEPTH_DEF     = 32;
  localparam int MAX_BURST           = 32;
  localparam int SEQ_W               = 31;
  localparam int CFG_W               = 6;
  localparam int BURST_W             = 6;
  localparam int APB_ADDR_W          = 3;
  localparam int APB_DATA_W          = 32;
  localparam int RST_START_WINDOW    = 1;
  localparam int RST_START_THRESHOLD = 2;

  typedef enum logic [1:0] {
    CMD_SUBMIT  = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_DROP   = 2'd2
  } kind_t;

  typedef enum logic {
    REG_START_WINDOW    = 1'b0,
    REG_START_THRESHOLD = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [SEQ_W-1:0] seq_number;
    logic             final_flag;
    logic [SEQ_W-1:0] ack_number;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] out_seq;
    logic             out_final;
    logic [CFG_W-1:0] window_now;
    logic             last_of_burst;
  } out_item_t;

  // one queue slot
  typedef struct packed {
    logic             fin;
    logic [SEQ_W-1:0] seq;
  } q_entry_t;

  // register write strobes towards the sequencer; value already has zero mapped to one
  typedef struct packed {
    logic             we_win;
    logic             we_thr;
    logic [CFG_W-1:0] value;
  } cfg_wr_t;

endpackage

// File: design/windowed_sender_congestion_ctrl_unit.sv
// Channel   Ports                                  Handshake
// -------   -------------------------------------  ------------------------------------
// input     start, busy, in_data (in_item_t)       beat taken when start && !busy
// result    out_valid, out_data (out_item_t)       one-cycle strobe, no back-pressure
// config    psel penable pwrite paddr pwdata       APB, pready tied high,
//           prdata pready                          reg 0 @0x0, reg 1 @0x4
//
// Steps: a submit is accepted, then checked for a burst; an ack passes ST_ACK,
//   then the burst check only when it closes a burst; a timeout is accepted, then
//   checked. A burst sends up to 32 segments, one queue read per result, through
//   the queue's single read port. Results are registered, as is the queue read.
// A dropped submission reports in the cycle after accept; busy stays low.
// Reset: rst_n synchronous, active low; window and threshold load 1 and 2.
// The result receiver cannot stall; each result beat shows for one cycle only.
module windowed_sender_congestion_ctrl_unit import wscc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item channel
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  output out_item_t             out_data,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic [CFG_W-1:0] start_win_r, start_win_nxt;
  logic [CFG_W-1:0] start_thr_r, start_thr_nxt;
  logic             wr_en;
  reg_idx_t         wr_idx;
  logic [CFG_W-1:0] wr_val;
  cfg_wr_t          cfg;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  q_entry_t         mem_wdata;
  q_entry_t         mem_rdata;

  assign pready = 1'b1;

  // word-aligned writes only; a zero value counts as one
  assign wr_en  = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);
  assign wr_idx = reg_idx_t'(paddr[2]);
  assign wr_val = (pwdata[CFG_W-1:0] == '0) ? CFG_W'(1) : pwdata[CFG_W-1:0];

  always_comb begin
    start_win_nxt = start_win_r;
    start_thr_nxt = start_thr_r;
    cfg           = '{we_win: 1'b0, we_thr: 1'b0, value: wr_val};
    if (wr_en) begin
      unique case (wr_idx)
        REG_START_WINDOW: begin
          start_win_nxt = wr_val;
          cfg.we_win    = 1'b1;
        end
        REG_START_THRESHOLD: begin
          start_thr_nxt = wr_val;
          cfg.we_thr    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_win_r <= CFG_W'(RST_START_WINDOW);
      start_thr_r <= CFG_W'(RST_START_THRESHOLD);
    end else begin
      start_win_r <= start_win_nxt;
      start_thr_r <= start_thr_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_idx)
      REG_START_WINDOW:    prdata[CFG_W-1:0] = start_win_r;
      REG_START_THRESHOLD: prdata[CFG_W-1:0] = start_thr_r;
      default: ;
    endcase
  end

  // sequencer: queue bookkeeping, window control, burst issue
  wscc_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // segment ring, one write and one registered read per cycle
  wscc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_queue (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: design/wscc_queue.sv
module wscc_queue import wscc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  q_entry_t         wdata,
  input  logic [IDX_W-1:0] raddr,
  output q_entry_t         rdata
);

  q_entry_t mem [QUEUE_DEPTH];
  q_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/wscc_ctrl.sv
module wscc_ctrl import wscc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  input  cfg_wr_t          cfg,
  output logic             out_valid,
  output out_item_t        out_data,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output q_entry_t         mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  q_entry_t         mem_rdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int VW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_CHECK,
    ST_BURST
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [VW-1:0]      window_r, window_nxt;
  logic [VW-1:0]      thr_r, thr_nxt;
  logic [BURST_W-1:0] acks_r, acks_nxt;
  logic [BURST_W-1:0] rem_r, rem_nxt;
  logic               final_seen_r, final_seen_nxt;
  logic               force_r, force_nxt;
  kind_t              kind_r, kind_nxt;
  logic [SEQ_W-1:0]   ack_num_r, ack_num_nxt;

  logic               out_vld_r, out_vld_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic               out_drop_r, out_drop_nxt;
  logic               out_last_r, out_last_nxt;
  logic [CFG_W-1:0]   out_win_r, out_win_nxt;

  logic               pop;
  logic [CNT_W-1:0]   cnt_after;
  logic [VW:0]        grown;
  logic [VW-1:0]      half_win;
  logic [VW-1:0]      min_wc;
  logic [BURST_W-1:0] burst_n;
  logic               go;
  logic [VW-1:0]      cfg_win;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = i + IDX_W'(1);
    return r;
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign mem_waddr = tail_r;
  assign mem_wdata = '{fin: in_data.final_flag, seq: in_data.seq_number};
  assign mem_raddr = (state_r == ST_BURST) ? ptr_r : head_r;

  // compare of the head entry against the ack number
  assign pop       = (count_r != '0) && (ack_num_r >= mem_rdata.seq);
  assign cnt_after = count_r - CNT_W'(pop);

  // window growth, saturating at the queue depth
  always_comb begin
    if (window_r < thr_r) grown = {window_r, 1'b0};
    else grown = {1'b0, window_r} + (VW+1)'(1);
    if (grown > (VW+1)'(QUEUE_DEPTH)) grown = (VW+1)'(QUEUE_DEPTH);
  end

  assign half_win = (window_r >> 1) == '0 ? VW'(1) : (window_r >> 1);

  always_comb begin
    min_wc = (window_r < VW'(count_r)) ? window_r : VW'(count_r);
    if (min_wc > VW'(MAX_BURST)) burst_n = BURST_W'(MAX_BURST);
    else burst_n = BURST_W'(min_wc);
  end

  assign go = force_r || ((acks_r == '0) &&
              ((VW'(count_r) >= window_r) || (final_seen_r && count_r != '0)));

  assign cfg_win = (VW'(cfg.value) > VW'(QUEUE_DEPTH)) ? VW'(QUEUE_DEPTH) : VW'(cfg.value);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    window_nxt     = window_r;
    thr_nxt        = thr_r;
    acks_nxt       = acks_r;
    rem_nxt        = rem_r;
    final_seen_nxt = final_seen_r;
    force_nxt      = force_r;
    kind_nxt       = kind_r;
    ack_num_nxt    = ack_num_r;
    out_vld_nxt    = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_drop_nxt   = out_drop_r;
    out_last_nxt   = out_last_r;
    out_win_nxt    = out_win_r;
    mem_we         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.cmd)
            CMD_SUBMIT: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                out_vld_nxt  = 1'b1;
                out_kind_nxt = KIND_DROP;
                out_drop_nxt = 1'b1;
                out_last_nxt = 1'b1;
                out_win_nxt  = window_r[CFG_W-1:0];
              end else begin
                mem_we    = 1'b1;
                tail_nxt  = idx_inc(tail_r);
                count_nxt = count_r + CNT_W'(1);
                if (in_data.final_flag) final_seen_nxt = 1'b1;
                kind_nxt  = KIND_SEND;
                force_nxt = 1'b0;
                state_nxt = ST_CHECK;
              end
            end
            CMD_ACK: begin
              if (acks_r != '0) begin
                ack_num_nxt = in_data.ack_number;
                state_nxt   = ST_ACK;
              end
            end
            CMD_TIMEOUT: begin
              if (acks_r != '0) begin
                thr_nxt    = half_win;
                window_nxt = VW'(1);
                kind_nxt   = KIND_RESEND;
                force_nxt  = 1'b1;
                state_nxt  = ST_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ACK: begin
        if (pop) begin
          head_nxt  = idx_inc(head_r);
          count_nxt = cnt_after;
        end
        acks_nxt = acks_r - BURST_W'(1);
        if (acks_r == BURST_W'(1)) begin
          window_nxt = VW'(grown);
          if (cnt_after == '0) final_seen_nxt = 1'b0;
          kind_nxt  = KIND_SEND;
          force_nxt = 1'b0;
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        state_nxt = ST_IDLE;
        if (go) begin
          acks_nxt = burst_n;
          rem_nxt  = burst_n;
          ptr_nxt  = head_r;
          if (burst_n != '0) state_nxt = ST_BURST;
        end
      end
      ST_BURST: begin
        out_vld_nxt  = 1'b1;
        out_kind_nxt = kind_r;
        out_drop_nxt = 1'b0;
        out_last_nxt = (rem_r == BURST_W'(1));
        out_win_nxt  = window_r[CFG_W-1:0];
        ptr_nxt      = idx_inc(ptr_r);
        rem_nxt      = rem_r - BURST_W'(1);
        if (rem_r == BURST_W'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg.we_win) window_nxt = cfg_win;
    if (cfg.we_thr) thr_nxt = VW'(cfg.value);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      window_r     <= VW'(RST_START_WINDOW);
      thr_r        <= VW'(RST_START_THRESHOLD);
      acks_r       <= '0;
      rem_r        <= '0;
      final_seen_r <= 1'b0;
      force_r      <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      window_r     <= window_nxt;
      thr_r        <= thr_nxt;
      acks_r       <= acks_nxt;
      rem_r        <= rem_nxt;
      final_seen_r <= final_seen_nxt;
      force_r      <= force_nxt;
      out_vld_r    <= out_vld_nxt;
    end
    ptr_r      <= ptr_nxt;
    kind_r     <= kind_nxt;
    ack_num_r  <= ack_num_nxt;
    out_kind_r <= out_kind_nxt;
    out_drop_r <= out_drop_nxt;
    out_last_r <= out_last_nxt;
    out_win_r  <= out_win_nxt;
  end

  // seq and final come straight from the queue's read register, zeroed for a drop
  assign out_valid              = out_vld_r;
  assign out_data.kind          = out_kind_r;
  assign out_data.out_seq       = out_drop_r ? '0 : mem_rdata.seq;
  assign out_data.out_final     = out_drop_r ? 1'b0 : mem_rdata.fin;
  assign out_data.window_now    = out_win_r;
  assign out_data.last_of_burst = out_last_r;

endmodule
